[hdl/cma_pkg.sv]
// cma_pkg: types, constants and beat structs for the channel measurement accumulator
// no dependencies; imported by cma_ctrl and channel_measurement_accumulator

package cma_pkg;

  localparam int ACC_LEN      = 256;
  localparam int NUM_PASSES   = 64;
  localparam int ACC_AW       = $clog2(ACC_LEN);
  localparam int CLR_W        = ACC_AW + 1;
  localparam int PASS_W       = $clog2(NUM_PASSES + 1);

  localparam logic [15:0] RELOAD_RESET  = 16'd9604;
  localparam logic [15:0] TIMEOUT_LIMIT = 16'd10;

  localparam logic [1:0] MODE_SAMPLE  = 2'd0;
  localparam logic [1:0] MODE_CONTROL = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  localparam logic [1:0] CS_CODE_IDLE = 2'd0;
  localparam logic [1:0] CS_CODE_WAIT = 2'd1;
  localparam logic [1:0] CS_CODE_RUN  = 2'd2;
  localparam logic [1:0] CS_CODE_END  = 2'd3;

  localparam logic [1:0] AS_CODE_IDLE  = 2'd0;
  localparam logic [1:0] AS_CODE_CLEAR = 2'd1;
  localparam logic [1:0] AS_CODE_MEAS  = 2'd2;
  localparam logic [1:0] AS_CODE_ERR   = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_READ  = 3'd1,
    OP_CLEAR = 3'd2,
    OP_ADD   = 3'd3,
    OP_ZERO  = 3'd4
  } mem_op_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] sample;
    logic [7:0]         read_index;
    logic               start_request;
    logic               remote_pn_on;
    logic               link_alarm;
    logic               hw_alarm;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         control_state;
    logic [1:0]         accumulate_state;
    logic               request_active;
    logic               gain_hold;
    logic               data_new;
    logic signed [31:0] read_value;
  } out_beat_t;

  typedef struct packed {
    logic [1:0] control_state;
    logic [1:0] accumulate_state;
    logic       request_active;
    logic       gain_hold;
    logic       data_new;
  } status_t;

  typedef struct packed {
    mem_op_t            op;
    logic [ACC_AW-1:0]  addr;
    logic signed [15:0] sample;
    logic               in_range;
  } mem_cmd_t;

endpackage

[hdl/channel_measurement_accumulator.sv]
// channel_measurement_accumulator: top level, sum store with forwarding and output register
// uses cma_pkg and cma_ctrl
//
//  port group   dir  handshake        payload
//  in_*         in   in_valid/ready   in_beat_t   (sample, control or read beat)
//  out_*        out  out_valid/ready  out_beat_t  (status and read value)
//  cfg_*        in   cfg_wr_en        16 bit timeout reload
//
// one beat per cycle while out_ready is high; results pass store stage then output register
// store read at accept, sum written back as store stage fires, same-entry hazard forwarded
// store entries read as zero after reset through per-entry valid bits, no clearing pass
// out_ready low stalls the store stage and then in_ready

module channel_measurement_accumulator import cma_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  mem_cmd_t cmd;
  status_t  status;

  logic               in_fire;
  logic               out_load;
  logic               s1_fire;
  logic               s1_we;
  logic signed [31:0] s1_wd;
  logic signed [31:0] old_val;
  logic signed [32:0] sum;
  logic signed [31:0] sat_sum;

  logic               s1_v_r;
  mem_cmd_t           s1_cmd_r;
  status_t            s1_stat_r;
  logic               fwd_hit_r;
  logic signed [31:0] fwd_data_r;
  logic signed [31:0] mem_q_r;
  logic               vld_q_r;
  logic [ACC_LEN-1:0] vld_r;
  logic               out_v_r;
  out_beat_t          out_data_r;

  logic signed [31:0] mem [ACC_LEN];

  cma_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .beat_fire   (in_fire),
    .beat        (in_data),
    .cmd         (cmd),
    .status      (status)
  );

  assign out_load = !out_v_r || out_ready;
  assign s1_fire  = s1_v_r && out_load;
  assign in_ready = !s1_v_r || out_load;
  assign in_fire  = in_valid && in_ready;

  assign old_val = fwd_hit_r ? fwd_data_r : (vld_q_r ? mem_q_r : 32'sd0);
  assign sum     = {old_val[31], old_val} + 33'(s1_cmd_r.sample);

  always_comb begin
    if (sum[32] != sum[31]) begin
      sat_sum = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_sum = sum[31:0];
    end
  end

  assign s1_we = s1_fire && (s1_cmd_r.op == OP_CLEAR || s1_cmd_r.op == OP_ADD
                             || s1_cmd_r.op == OP_ZERO);
  assign s1_wd = (s1_cmd_r.op == OP_ADD) ? sat_sum : 32'sd0;

  // store array, one write and one read port
  always_ff @(posedge clk) begin
    if (s1_we) begin
      mem[s1_cmd_r.addr] <= s1_wd;
    end
    if (in_fire) begin
      mem_q_r <= mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r   <= cmd;
      s1_stat_r  <= status;
      vld_q_r    <= vld_r[cmd.addr];
      fwd_hit_r  <= s1_we && (s1_cmd_r.addr == cmd.addr);
      fwd_data_r <= s1_wd;
    end
    if (s1_fire) begin
      out_data_r.control_state    <= s1_stat_r.control_state;
      out_data_r.accumulate_state <= s1_stat_r.accumulate_state;
      out_data_r.request_active   <= s1_stat_r.request_active;
      out_data_r.gain_hold        <= s1_stat_r.gain_hold;
      out_data_r.data_new         <= s1_stat_r.data_new;
      out_data_r.read_value       <= (s1_cmd_r.op == OP_READ && s1_cmd_r.in_range)
                                     ? old_val : 32'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      vld_r   <= '0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_fire) begin
        s1_v_r <= 1'b0;
      end
      if (s1_fire) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (s1_we) begin
        vld_r[s1_cmd_r.addr] <= 1'b1;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

[hdl/cma_ctrl.sv]
// cma_ctrl: measurement controller, accumulator sequencer, timeout and flags
// uses cma_pkg; issues one store command and the updated status per accepted beat

module cma_ctrl import cma_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        beat_fire,
  input  in_beat_t    beat,
  output mem_cmd_t    cmd,
  output status_t     status
);

  typedef enum logic [3:0] {
    CS_IDLE = 4'b0001,
    CS_WAIT = 4'b0010,
    CS_RUN  = 4'b0100,
    CS_END  = 4'b1000
  } ctrl_state_t;

  typedef enum logic [3:0] {
    AS_IDLE  = 4'b0001,
    AS_CLEAR = 4'b0010,
    AS_MEAS  = 4'b0100,
    AS_ERR   = 4'b1000
  } acc_state_t;

  ctrl_state_t       cs_r, cs_nxt;
  acc_state_t        as_r, as_nxt;
  logic [15:0]       reload_r;
  logic [15:0]       tmo_cnt_r, tmo_cnt_nxt;
  logic [CLR_W-1:0]  clr_pos_r, clr_pos_nxt;
  logic [ACC_AW-1:0] entry_r, entry_nxt;
  logic [PASS_W-1:0] pass_r, pass_nxt;
  logic              running_r, running_nxt;
  logic              request_r, request_nxt;
  logic              hold_r, hold_nxt;
  logic              fresh_r, fresh_nxt;

  logic [15:0]       tc_dec;
  logic              tmo;
  logic [CLR_W-1:0]  entry_inc;
  logic [PASS_W-1:0] pass_chk;
  logic              wrap;

  always_comb begin
    cs_nxt      = cs_r;
    as_nxt      = as_r;
    tmo_cnt_nxt = tmo_cnt_r;
    clr_pos_nxt = clr_pos_r;
    entry_nxt   = entry_r;
    pass_nxt    = pass_r;
    running_nxt = running_r;
    request_nxt = request_r;
    hold_nxt    = hold_r;
    fresh_nxt   = fresh_r;

    cmd.op       = OP_NONE;
    cmd.addr     = ACC_AW'(beat.read_index);
    cmd.sample   = beat.sample;
    cmd.in_range = (32'(beat.read_index) < ACC_LEN);

    tc_dec    = (tmo_cnt_r != 16'd0) ? tmo_cnt_r - 16'd1 : 16'd0;
    tmo       = tc_dec < TIMEOUT_LIMIT;
    entry_inc = CLR_W'(entry_r) + CLR_W'(1);
    wrap      = (entry_inc == CLR_W'(ACC_LEN));
    pass_chk  = wrap ? pass_r + PASS_W'(1) : pass_r;

    unique case (beat.mode)
      MODE_SAMPLE: begin
        unique case (as_r)
          AS_IDLE: begin
            if (running_r) begin
              as_nxt      = AS_CLEAR;
              clr_pos_nxt = '0;
              fresh_nxt   = 1'b1;
            end
          end
          AS_CLEAR: begin
            if (clr_pos_r < CLR_W'(ACC_LEN)) begin
              cmd.op      = OP_CLEAR;
              cmd.addr    = clr_pos_r[ACC_AW-1:0];
              clr_pos_nxt = clr_pos_r + CLR_W'(1);
            end else begin
              as_nxt    = AS_MEAS;
              entry_nxt = '0;
              pass_nxt  = '0;
            end
            if (!running_r) begin
              as_nxt = AS_ERR;
            end
          end
          AS_MEAS: begin
            cmd.op    = OP_ADD;
            cmd.addr  = entry_r;
            entry_nxt = wrap ? '0 : entry_inc[ACC_AW-1:0];
            pass_nxt  = pass_chk;
            if (!running_r) begin
              as_nxt = AS_ERR;
            end
            if (32'(pass_chk) >= NUM_PASSES) begin
              as_nxt      = AS_IDLE;
              clr_pos_nxt = '0;
              pass_nxt    = '0;
              entry_nxt   = '0;
              running_nxt = 1'b0;
            end
          end
          AS_ERR: begin
            cmd.op    = OP_ZERO;
            cmd.addr  = '0;
            as_nxt    = AS_IDLE;
            fresh_nxt = 1'b0;
          end
          default: begin
            as_nxt = AS_IDLE;
          end
        endcase
      end
      MODE_CONTROL: begin
        if (beat.start_request) begin
          request_nxt = 1'b1;
        end
        unique case (cs_r)
          CS_IDLE: begin
            if (request_nxt) begin
              cs_nxt = CS_WAIT;
            end
          end
          CS_WAIT: begin
            tmo_cnt_nxt = tc_dec;
            if (tmo || beat.link_alarm || beat.hw_alarm) begin
              cs_nxt      = CS_END;
              running_nxt = 1'b0;
              request_nxt = 1'b0;
              as_nxt      = AS_ERR;
            end else if (beat.remote_pn_on) begin
              running_nxt = 1'b1;
              hold_nxt    = 1'b1;
              cs_nxt      = CS_RUN;
              tmo_cnt_nxt = reload_r;
            end
          end
          CS_RUN: begin
            tmo_cnt_nxt = tc_dec;
            if (tmo) begin
              cs_nxt      = CS_END;
              running_nxt = 1'b0;
              request_nxt = 1'b0;
              as_nxt      = AS_ERR;
              hold_nxt    = 1'b0;
            end else if (!beat.remote_pn_on) begin
              request_nxt = 1'b0;
              running_nxt = 1'b0;
              cs_nxt      = CS_IDLE;
              tmo_cnt_nxt = reload_r;
              as_nxt      = AS_ERR;
              hold_nxt    = 1'b0;
            end else if (!running_r) begin
              request_nxt = 1'b0;
              cs_nxt      = CS_END;
              hold_nxt    = 1'b0;
            end
          end
          CS_END: begin
            if (!beat.remote_pn_on) begin
              cs_nxt      = CS_IDLE;
              tmo_cnt_nxt = reload_r;
            end
          end
          default: begin
            cs_nxt = CS_IDLE;
          end
        endcase
      end
      MODE_READ: begin
        cmd.op = OP_READ;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (cs_nxt)
      CS_WAIT: status.control_state = CS_CODE_WAIT;
      CS_RUN:  status.control_state = CS_CODE_RUN;
      CS_END:  status.control_state = CS_CODE_END;
      default: status.control_state = CS_CODE_IDLE;
    endcase
    unique case (as_nxt)
      AS_CLEAR: status.accumulate_state = AS_CODE_CLEAR;
      AS_MEAS:  status.accumulate_state = AS_CODE_MEAS;
      AS_ERR:   status.accumulate_state = AS_CODE_ERR;
      default:  status.accumulate_state = AS_CODE_IDLE;
    endcase
    status.request_active = request_nxt;
    status.gain_hold      = hold_nxt;
    status.data_new       = fresh_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r      <= CS_IDLE;
      as_r      <= AS_IDLE;
      reload_r  <= RELOAD_RESET;
      tmo_cnt_r <= RELOAD_RESET;
      clr_pos_r <= '0;
      entry_r   <= '0;
      pass_r    <= '0;
      running_r <= 1'b0;
      request_r <= 1'b0;
      hold_r    <= 1'b0;
      fresh_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        reload_r <= cfg_wr_data;
      end
      if (beat_fire) begin
        cs_r      <= cs_nxt;
        as_r      <= as_nxt;
        tmo_cnt_r <= tmo_cnt_nxt;
        clr_pos_r <= clr_pos_nxt;
        entry_r   <= entry_nxt;
        pass_r    <= pass_nxt;
        running_r <= running_nxt;
        request_r <= request_nxt;
        hold_r    <= hold_nxt;
        fresh_r   <= fresh_nxt;
      end
    end
  end

endmodule
